@@ design/ldk_pkg.sv @@
`default_nettype none

package ldk_pkg;

    // Field and datapath widths
    localparam int T_W    = 56;          // time coordinate
    localparam int E_W    = 40;          // energy offset magnitude
    localparam int K_W    = 48;          // slip coefficients and period
    localparam int E2_W   = 2 * E_W;     // dE^2
    localparam int E3_W   = 3 * E_W;     // dE^3
    localparam int P0_W   = K_W + E_W;   // |k0*dE|
    localparam int P1_W   = K_W + E2_W;  // |k1*dE^2|
    localparam int P2_W   = K_W + E3_W;  // |k2*dE^3|
    localparam int S0     = 26;          // scale of k0 term into x
    localparam int S1     = 74;          // scale of k1 term into x
    localparam int S2     = 122;         // scale of k2 term into x
    localparam int X_W    = 63;          // slip sum, signed, LSB 2^-62
    localparam int XM_W   = 62;          // slip sum magnitude
    localparam int FRAC_W = 62;          // fraction bits of x
    localparam int N_W    = K_W + XM_W;  // |period*x|
    localparam int D_W    = 64;          // denominator 1 - x
    localparam int Q_W    = 48;          // quotient bits
    localparam int INC_W  = Q_W + 2;     // signed increment
    localparam int SUM_W  = T_W + 1;     // time plus increment
    localparam int MUL_CW = 16;          // multiplier chunk width

    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [D_W-1:0] ONE62 = D_W'(1) << FRAC_W;
    localparam logic [T_W-1:0] TMAX  = {1'b0, {(T_W - 1){1'b1}}};
    localparam logic [T_W-1:0] TMIN  = {1'b1, {(T_W - 1){1'b0}}};

    localparam logic [1:0] MODE_SIMPLE = 2'd0;
    localparam logic [1:0] MODE_ORDER1 = 2'd1;
    localparam logic [1:0] MODE_ORDER2 = 2'd2;
    localparam logic [1:0] MODE_ORDER3 = 2'd3;

    typedef enum logic [2:0] {
        REG_ORDER_MODE   = 3'd0,
        REG_DRIFT_PERIOD = 3'd1,
        REG_SLIP_K0      = 3'd2,
        REG_SLIP_K1      = 3'd3,
        REG_SLIP_K2      = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [T_W-1:0] time_in;
        logic signed [E_W-1:0] energy_offset;
        logic                  last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [T_W-1:0] time_out;
        logic                  overflow_flag;
        logic                  last_out;
    } t_out_item;

    typedef struct packed {
        logic [T_W-1:0] tcoord;
        logic           dneg;
        logic           last;
        logic [E_W-1:0] e1;
    } t_pl_a;

    typedef struct packed {
        logic [T_W-1:0]  tcoord;
        logic            dneg;
        logic            last;
        logic [E_W-1:0]  e1;
        logic [E2_W-1:0] e2;
    } t_pl_b;

    typedef struct packed {
        logic [T_W-1:0]  tcoord;
        logic            dneg;
        logic            last;
        logic [E2_W-1:0] e2;
        logic [E3_W-1:0] e3;
    } t_pl_c;

    typedef struct packed {
        logic [T_W-1:0]  tcoord;
        logic            dneg;
        logic            last;
        logic [E3_W-1:0] e3;
        logic [P0_W-1:0] p0;
    } t_pl_d;

    typedef struct packed {
        logic [T_W-1:0]  tcoord;
        logic            dneg;
        logic            last;
        logic [P0_W-1:0] p0;
        logic [P1_W-1:0] p1;
    } t_pl_e;

    typedef struct packed {
        logic [T_W-1:0] tcoord;
        logic           last;
        logic           xneg;
        logic           dbad;
        logic [D_W-1:0] d;
    } t_pl_f;

    typedef struct packed {
        logic [T_W-1:0] tcoord;
        logic           last;
        logic           xneg;
        logic           dbad;
        logic [Q_W-1:0] qs;
        logic           sts;
    } t_pl_q;

endpackage

`default_nettype wire

@@ design/ldk_mul.sv @@
`default_nettype none

// Unsigned multiplier, one MUL_CW-bit chunk of b per stage.
module ldk_mul
    import ldk_pkg::*;
#(
    parameter int AW = 48,
    parameter int BW = 48,
    parameter int PW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    input  logic [PW-1:0]    i_pl,
    output logic             o_valid,
    output logic [AW+BW-1:0] o_prod,
    output logic [PW-1:0]    o_pl
);

    localparam int NC    = (BW + MUL_CW - 1) / MUL_CW;
    localparam int BP    = NC * MUL_CW;
    localparam int ACC_W = AW + BP;

    logic             r_valid [NC];
    logic [AW-1:0]    r_a     [NC];
    logic [BP-1:0]    r_b     [NC];
    logic [ACC_W-1:0] r_acc   [NC];
    logic [PW-1:0]    r_pl    [NC];

    for (genvar g = 0; g < NC; g++) begin : g_stage
        logic                w_valid;
        logic [AW-1:0]       w_a;
        logic [BP-1:0]       w_b;
        logic [ACC_W-1:0]    w_acc;
        logic [PW-1:0]       w_pl;
        logic [AW+MUL_CW-1:0] w_pp;

        if (g == 0) begin : g_head
            assign w_valid = i_valid;
            assign w_a     = i_a;
            assign w_b     = BP'(i_b);
            assign w_acc   = '0;
            assign w_pl    = i_pl;
        end else begin : g_link
            assign w_valid = r_valid[g-1];
            assign w_a     = r_a[g-1];
            assign w_b     = r_b[g-1];
            assign w_acc   = r_acc[g-1];
            assign w_pl    = r_pl[g-1];
        end

        assign w_pp = w_a * w_b[g*MUL_CW +: MUL_CW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= w_valid;
            end
            r_a[g]   <= w_a;
            r_b[g]   <= w_b;
            r_pl[g]  <= w_pl;
            r_acc[g] <= w_acc + (ACC_W'(w_pp) << (g * MUL_CW));
        end
    end

    assign o_valid = r_valid[NC-1];
    assign o_prod  = r_acc[NC-1][AW+BW-1:0];
    assign o_pl    = r_pl[NC-1];

endmodule

`default_nettype wire

@@ design/ldk_div.sv @@
`default_nettype none

// Restoring divider, one quotient bit per stage. The quotient must fit Q_W bits.
module ldk_div
    import ldk_pkg::*;
#(
    parameter int PW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    input  logic [PW-1:0]  i_pl,
    output logic           o_valid,
    output logic [Q_W-1:0] o_quot,
    output logic           o_rem_nz,
    output logic [PW-1:0]  o_pl
);

    logic           r_valid [Q_W];
    logic [D_W-1:0] r_rem   [Q_W];
    logic [Q_W-1:0] r_low   [Q_W];
    logic [Q_W-1:0] r_quot  [Q_W];
    logic [D_W-1:0] r_den   [Q_W];
    logic [PW-1:0]  r_pl    [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic           w_valid;
        logic [D_W-1:0] w_rem;
        logic [Q_W-1:0] w_low;
        logic [Q_W-1:0] w_quot;
        logic [D_W-1:0] w_den;
        logic [PW-1:0]  w_pl;
        logic [D_W:0]   w_sh;
        logic [D_W:0]   w_diff;
        logic           w_ge;

        if (g == 0) begin : g_head
            assign w_valid = i_valid;
            assign w_rem   = D_W'(i_num[N_W-1:Q_W]);
            assign w_low   = i_num[Q_W-1:0];
            assign w_quot  = '0;
            assign w_den   = i_den;
            assign w_pl    = i_pl;
        end else begin : g_link
            assign w_valid = r_valid[g-1];
            assign w_rem   = r_rem[g-1];
            assign w_low   = r_low[g-1];
            assign w_quot  = r_quot[g-1];
            assign w_den   = r_den[g-1];
            assign w_pl    = r_pl[g-1];
        end

        // Bring down the next numerator bit, subtract when it fits.
        assign w_sh   = {w_rem, w_low[Q_W-1-g]};
        assign w_diff = w_sh - {1'b0, w_den};
        assign w_ge   = w_sh >= {1'b0, w_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else begin
                r_valid[g] <= w_valid;
            end
            r_rem[g]  <= w_ge ? w_diff[D_W-1:0] : w_sh[D_W-1:0];
            r_low[g]  <= w_low;
            r_quot[g] <= {w_quot[Q_W-2:0], w_ge};
            r_den[g]  <= w_den;
            r_pl[g]   <= w_pl;
        end
    end

    assign o_valid  = r_valid[Q_W-1];
    assign o_quot   = r_quot[Q_W-1];
    assign o_rem_nz = |r_rem[Q_W-1];
    assign o_pl     = r_pl[Q_W-1];

endmodule

`default_nettype wire

@@ design/longitudinal_drift_kick.sv @@
// Longitudinal drift of one particle per transaction.
// Input: pulse start with i_item (time, energy offset, last marker); busy is
// always low, so a new transaction may be issued on every clock.
// Output: o_strobe is high for one cycle with o_item (drifted time, overflow
// flag, last marker). Results leave in issue order; one result per cycle is
// sustained. The pipeline is six chunked multipliers (dE^2, dE^3, k0*dE,
// k1*dE^2, k2*dE^3, period*x, 28 stages together), the 48-stage quotient
// pipeline and six single register stages.
// Configuration: APB, 64-bit data, register i at byte address 8*i; pready
// is tied high. Write only while no transaction is in flight.
// Reset (synchronous, active low) clears all stage valid bits and loads the
// registers: order mode 1, period and coefficients zero.
// The receiver cannot stall; there is no output backpressure.
`default_nettype none

module longitudinal_drift_kick
    import ldk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_in_item          i_item,
    output logic              o_strobe,
    output t_out_item         o_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // Pipeline depth, stage by stage
    localparam int NC_A = (E_W + MUL_CW - 1) / MUL_CW;
    localparam int NC_B = (E2_W + MUL_CW - 1) / MUL_CW;
    localparam int NC_C = (K_W + MUL_CW - 1) / MUL_CW;
    localparam int NC_D = (E2_W + MUL_CW - 1) / MUL_CW;
    localparam int NC_E = (E3_W + MUL_CW - 1) / MUL_CW;
    localparam int NC_F = (XM_W + MUL_CW - 1) / MUL_CW;
    localparam int LAT  = 6 + NC_A + NC_B + NC_C + NC_D + NC_E + NC_F + Q_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [1:0]     r_order_mode;
    logic [K_W-1:0] r_drift_period;
    logic [K_W-1:0] r_k0;
    logic [K_W-1:0] r_k1;
    logic [K_W-1:0] r_k2;
    logic           w_cfg_wr;
    t_reg_idx       w_cfg_idx;

    assign pready    = 1'b1;
    assign busy      = 1'b0;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode   <= MODE_ORDER1;
            r_drift_period <= '0;
            r_k0           <= '0;
            r_k1           <= '0;
            r_k2           <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_ORDER_MODE:   r_order_mode   <= pwdata[1:0];
                REG_DRIFT_PERIOD: r_drift_period <= pwdata[K_W-1:0];
                REG_SLIP_K0:      r_k0           <= pwdata[K_W-1:0];
                REG_SLIP_K1:      r_k1           <= pwdata[K_W-1:0];
                REG_SLIP_K2:      r_k2           <= pwdata[K_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_ORDER_MODE:   prdata = DATA_W'(r_order_mode);
            REG_DRIFT_PERIOD: prdata = DATA_W'(r_drift_period);
            REG_SLIP_K0:      prdata = DATA_W'(r_k0);
            REG_SLIP_K1:      prdata = DATA_W'(r_k1);
            REG_SLIP_K2:      prdata = DATA_W'(r_k2);
            default:          prdata = '0;
        endcase
    end

    // Coefficient magnitudes; the datapath works in sign/magnitude so that
    // every scaling can floor with a sticky bit.
    logic [K_W-1:0] w_k0_mag;
    logic [K_W-1:0] w_k1_mag;
    logic [K_W-1:0] w_k2_mag;
    logic           w_use_k1;
    logic           w_use_k2;
    logic           w_simple;

    assign w_k0_mag = r_k0[K_W-1] ? -r_k0 : r_k0;
    assign w_k1_mag = r_k1[K_W-1] ? -r_k1 : r_k1;
    assign w_k2_mag = r_k2[K_W-1] ? -r_k2 : r_k2;
    assign w_use_k1 = r_order_mode inside {MODE_ORDER2, MODE_ORDER3};
    assign w_use_k2 = r_order_mode == MODE_ORDER3;
    assign w_simple = r_order_mode == MODE_SIMPLE;

    // ------------------------------------------------------------------
    // Input stage: capture the transaction, split dE into sign/magnitude
    // ------------------------------------------------------------------
    logic  r_in_valid;
    t_pl_a r_in_pl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
        r_in_pl.tcoord <= i_item.time_in;
        r_in_pl.dneg   <= i_item.energy_offset[E_W-1];
        r_in_pl.last   <= i_item.last_in;
        r_in_pl.e1     <= i_item.energy_offset[E_W-1] ? E_W'(-i_item.energy_offset)
                                                      : E_W'(i_item.energy_offset);
    end

    // ------------------------------------------------------------------
    // Powers of |dE| and the three slip products
    // ------------------------------------------------------------------
    logic            w_a_valid;
    logic [E2_W-1:0] w_e2;
    t_pl_a           w_pl_a;
    t_pl_b           w_pl_b_in;
    logic            w_b_valid;
    logic [E3_W-1:0] w_e3;
    t_pl_b           w_pl_b;
    t_pl_c           w_pl_c_in;
    logic            w_c_valid;
    logic [P0_W-1:0] w_p0;
    t_pl_c           w_pl_c;
    t_pl_d           w_pl_d_in;
    logic            w_d_valid;
    logic [P1_W-1:0] w_p1;
    t_pl_d           w_pl_d;
    t_pl_e           w_pl_e_in;
    logic            w_e_valid;
    logic [P2_W-1:0] w_p2;
    t_pl_e           w_pl_e;

    ldk_mul #(.AW(E_W), .BW(E_W), .PW($bits(t_pl_a))) u_mul_e2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_a     (r_in_pl.e1),
        .i_b     (r_in_pl.e1),
        .i_pl    (r_in_pl),
        .o_valid (w_a_valid),
        .o_prod  (w_e2),
        .o_pl    (w_pl_a)
    );

    assign w_pl_b_in = '{tcoord: w_pl_a.tcoord, dneg: w_pl_a.dneg, last: w_pl_a.last,
                         e1: w_pl_a.e1, e2: w_e2};

    ldk_mul #(.AW(E_W), .BW(E2_W), .PW($bits(t_pl_b))) u_mul_e3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_a_valid),
        .i_a     (w_pl_a.e1),
        .i_b     (w_e2),
        .i_pl    (w_pl_b_in),
        .o_valid (w_b_valid),
        .o_prod  (w_e3),
        .o_pl    (w_pl_b)
    );

    assign w_pl_c_in = '{tcoord: w_pl_b.tcoord, dneg: w_pl_b.dneg, last: w_pl_b.last,
                         e2: w_pl_b.e2, e3: w_e3};

    ldk_mul #(.AW(E_W), .BW(K_W), .PW($bits(t_pl_c))) u_mul_p0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_b_valid),
        .i_a     (w_pl_b.e1),
        .i_b     (w_k0_mag),
        .i_pl    (w_pl_c_in),
        .o_valid (w_c_valid),
        .o_prod  (w_p0),
        .o_pl    (w_pl_c)
    );

    assign w_pl_d_in = '{tcoord: w_pl_c.tcoord, dneg: w_pl_c.dneg, last: w_pl_c.last,
                         e3: w_pl_c.e3, p0: w_p0};

    ldk_mul #(.AW(K_W), .BW(E2_W), .PW($bits(t_pl_d))) u_mul_p1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_c_valid),
        .i_a     (w_k1_mag),
        .i_b     (w_pl_c.e2),
        .i_pl    (w_pl_d_in),
        .o_valid (w_d_valid),
        .o_prod  (w_p1),
        .o_pl    (w_pl_d)
    );

    assign w_pl_e_in = '{tcoord: w_pl_d.tcoord, dneg: w_pl_d.dneg, last: w_pl_d.last,
                         p0: w_pl_d.p0, p1: w_p1};

    ldk_mul #(.AW(K_W), .BW(E3_W), .PW($bits(t_pl_e))) u_mul_p2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_d_valid),
        .i_a     (w_k2_mag),
        .i_b     (w_pl_d.e3),
        .i_pl    (w_pl_e_in),
        .o_valid (w_e_valid),
        .o_prod  (w_p2),
        .o_pl    (w_pl_e)
    );

    // ------------------------------------------------------------------
    // Scale each product into x's format (LSB 2^-62), flooring
    // ------------------------------------------------------------------
    logic                  w_neg0;
    logic                  w_neg1;
    logic                  w_neg2;
    logic [X_W-1:0]        w_m0;
    logic [X_W-1:0]        w_m1;
    logic [X_W-1:0]        w_m2;
    logic                  r_t_valid;
    logic [T_W-1:0]        r_t_tcoord;
    logic                  r_t_last;
    logic signed [X_W-1:0] r_t0;
    logic signed [X_W-1:0] r_t1;
    logic signed [X_W-1:0] r_t2;

    assign w_neg0 = r_k0[K_W-1] ^ w_pl_e.dneg;
    assign w_neg1 = r_k1[K_W-1];
    assign w_neg2 = r_k2[K_W-1] ^ w_pl_e.dneg;

    // Magnitude after the shift, plus one when a negative value drops bits.
    assign w_m0 = X_W'(w_pl_e.p0[P0_W-1:S0])
                + X_W'(w_neg0 & (|w_pl_e.p0[S0-1:0]));
    assign w_m1 = X_W'(w_pl_e.p1[P1_W-1:S1])
                + X_W'(w_neg1 & (|w_pl_e.p1[S1-1:0]));
    assign w_m2 = X_W'(w_p2[P2_W-1:S2])
                + X_W'(w_neg2 & (|w_p2[S2-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
        end else begin
            r_t_valid <= w_e_valid;
        end
        r_t_tcoord <= w_pl_e.tcoord;
        r_t_last   <= w_pl_e.last;
        r_t0       <= w_neg0 ? -w_m0 : w_m0;
        r_t1       <= w_neg1 ? -w_m1 : w_m1;
        r_t2       <= w_neg2 ? -w_m2 : w_m2;
    end

    // ------------------------------------------------------------------
    // Slip sum truncated to the selected order
    // ------------------------------------------------------------------
    logic                  r_x_valid;
    logic [T_W-1:0]        r_x_tcoord;
    logic                  r_x_last;
    logic signed [X_W-1:0] r_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid <= 1'b0;
        end else begin
            r_x_valid <= r_t_valid;
        end
        r_x_tcoord <= r_t_tcoord;
        r_x_last   <= r_t_last;
        r_x        <= r_t0 + (w_use_k1 ? r_t1 : '0) + (w_use_k2 ? r_t2 : '0);
    end

    // ------------------------------------------------------------------
    // |x| for the product, d = 1 - x for the quotient
    // ------------------------------------------------------------------
    logic            w_xneg;
    logic [D_W-1:0]  w_d;
    logic            r_y_valid;
    logic [XM_W-1:0] r_y_xm;
    t_pl_f           r_y_pl;

    assign w_xneg = r_x[X_W-1];
    assign w_d    = ONE62 - {{(D_W - X_W){r_x[X_W-1]}}, r_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_valid <= 1'b0;
        end else begin
            r_y_valid <= r_x_valid;
        end
        r_y_xm        <= w_xneg ? XM_W'(-r_x) : XM_W'(r_x);
        r_y_pl.tcoord <= r_x_tcoord;
        r_y_pl.last   <= r_x_last;
        r_y_pl.xneg   <= w_xneg;
        r_y_pl.d      <= w_d;
        r_y_pl.dbad   <= w_d[D_W-1] | (w_d == '0);
    end

    // ------------------------------------------------------------------
    // period * |x|, then the quotient by d
    // ------------------------------------------------------------------
    logic           w_f_valid;
    logic [N_W-1:0] w_num;
    t_pl_f          w_pl_f;
    t_pl_q          w_pl_q_in;
    logic           w_q_valid;
    logic [Q_W-1:0] w_quot;
    logic           w_rem_nz;
    t_pl_q          w_pl_q;

    ldk_mul #(.AW(K_W), .BW(XM_W), .PW($bits(t_pl_f))) u_mul_px (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_y_valid),
        .i_a     (r_drift_period),
        .i_b     (r_y_xm),
        .i_pl    (r_y_pl),
        .o_valid (w_f_valid),
        .o_prod  (w_num),
        .o_pl    (w_pl_f)
    );

    // The simple-mode increment is just the product scaled down; carry it
    // alongside the quotient.
    assign w_pl_q_in = '{tcoord: w_pl_f.tcoord, last: w_pl_f.last, xneg: w_pl_f.xneg,
                         dbad: w_pl_f.dbad, qs: w_num[N_W-1:FRAC_W],
                         sts: |w_num[FRAC_W-1:0]};

    ldk_div #(.PW($bits(t_pl_q))) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_f_valid),
        .i_num    (w_num),
        .i_den    (w_pl_f.d),
        .i_pl     (w_pl_q_in),
        .o_valid  (w_q_valid),
        .o_quot   (w_quot),
        .o_rem_nz (w_rem_nz),
        .o_pl     (w_pl_q)
    );

    // ------------------------------------------------------------------
    // Signed increment, floored toward minus infinity
    // ------------------------------------------------------------------
    logic [Q_W-1:0]          w_mag;
    logic                    w_rnd;
    logic [INC_W-1:0]        w_mag_up;
    logic                    r_i_valid;
    logic [T_W-1:0]          r_i_tcoord;
    logic                    r_i_last;
    logic                    r_i_bad;
    logic signed [INC_W-1:0] r_i_inc;

    assign w_mag    = w_simple ? w_pl_q.qs : w_quot;
    assign w_rnd    = w_simple ? w_pl_q.sts : w_rem_nz;
    assign w_mag_up = INC_W'(w_mag) + INC_W'(w_rnd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
        end else begin
            r_i_valid <= w_q_valid;
        end
        r_i_tcoord <= w_pl_q.tcoord;
        r_i_last   <= w_pl_q.last;
        r_i_bad    <= w_pl_q.dbad & ~w_simple;
        r_i_inc    <= w_pl_q.xneg ? -w_mag_up : INC_W'(w_mag);
    end

    // ------------------------------------------------------------------
    // Add, saturate to 56 bits, register the result
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] w_sum;
    logic             w_ovf;
    logic             r_out_valid;
    t_out_item        r_out;

    assign w_sum = {r_i_tcoord[T_W-1], r_i_tcoord}
                 + {{(SUM_W - INC_W){r_i_inc[INC_W-1]}}, r_i_inc};
    assign w_ovf = w_sum[SUM_W-1] ^ w_sum[SUM_W-2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_i_valid;
        end
        r_out.last_out <= r_i_last;
        if (r_i_bad) begin
            // Denominator not positive: pin to the top limit.
            r_out.time_out      <= TMAX;
            r_out.overflow_flag <= 1'b1;
        end else if (w_ovf) begin
            r_out.time_out      <= w_sum[SUM_W-1] ? TMIN : TMAX;
            r_out.overflow_flag <= 1'b1;
        end else begin
            r_out.time_out      <= w_sum[T_W-1:0];
            r_out.overflow_flag <= 1'b0;
        end
    end

    assign o_strobe = r_out_valid;
    assign o_item   = r_out;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("accepted transaction produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##LAT !o_strobe)
        else $error("result without an accepted transaction");

    a_flag_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_item.overflow_flag) |->
            (o_item.time_out == TMAX || o_item.time_out == TMIN))
        else $error("overflow flag with unsaturated time");

    a_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_y_valid && !w_simple) |-> !r_y_pl.dbad)
        else $error("slip sum reached one");
`endif

endmodule

`default_nettype wire

@@ tb/sv/ldk_checker.sv @@
`timescale 1ns / 1ps

module ldk_checker
    import ldk_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  t_in_item          i_item,
    input  logic              o_strobe,
    input  t_out_item         o_item,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output int                n_errors,
    output int                n_pending
);

    localparam logic signed [127:0] SAT_HI = (128'sd1 <<< 55) - 128'sd1;
    localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< 55);

    logic [1:0]         mode_q;
    logic [K_W-1:0]     period_q;
    logic signed [K_W-1:0] k0_q, k1_q, k2_q;

    t_out_item drift_q[$];
    int        n_issued;
    int        n_done;

    assign n_pending = n_issued - n_done;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_errors = n_errors + 1;
    endtask

    // Drifted time of one particle under the current register settings.
    function automatic t_out_item predict_drift(input t_in_item it);
        logic signed [E_W-1:0]  de;
        logic signed [80:0]     de2;
        logic signed [120:0]    de3;
        logic signed [87:0]     p0;
        logic signed [127:0]    p1;
        logic signed [167:0]    p2;
        logic signed [63:0]     x;
        logic signed [127:0]    sprod;
        logic [127:0]           num;
        logic [127:0]           xm;
        logic signed [64:0]     dd;
        logic [127:0]           quo;
        logic [127:0]           rem;
        logic signed [127:0]    inc;
        logic signed [127:0]    sum;
        t_out_item              r;
        de  = it.energy_offset;
        de2 = de * de;
        de3 = de2 * de;
        p0  = k0_q * de;
        p1  = k1_q * de2;
        p2  = k2_q * de3;
        x   = 64'(p0 >>> S0);
        if (mode_q == MODE_ORDER2 || mode_q == MODE_ORDER3) begin
            x = x + 64'(p1 >>> S1);
        end
        if (mode_q == MODE_ORDER3) begin
            x = x + 64'(p2 >>> S2);
        end
        r.last_out = it.last_in;
        r.overflow_flag = 1'b0;
        if (mode_q == MODE_SIMPLE) begin
            sprod = $signed({1'b0, period_q}) * x;
            inc   = sprod >>> FRAC_W;
        end else begin
            dd = (65'sd1 <<< FRAC_W) - x;
            if (dd <= 0) begin
                // denominator gone: pin to the top and flag
                r.time_out = TMAX;
                r.overflow_flag = 1'b1;
                return r;
            end
            xm  = (x < 0) ? 128'(-x) : 128'(x);
            num = {80'd0, period_q} * xm;
            quo = num / 128'(dd);
            rem = num % 128'(dd);
            if (x < 0) begin
                inc = -$signed(quo + ((rem != 0) ? 128'd1 : 128'd0));
            end else begin
                inc = $signed(quo);
            end
        end
        sum = it.time_in + inc;
        if (sum > SAT_HI) begin
            sum = SAT_HI;
            r.overflow_flag = 1'b1;
        end
        if (sum < SAT_LO) begin
            sum = SAT_LO;
            r.overflow_flag = 1'b1;
        end
        r.time_out = sum[T_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            mode_q   <= MODE_ORDER1;
            period_q <= '0;
            k0_q     <= '0;
            k1_q     <= '0;
            k2_q     <= '0;
            drift_q.delete();
            n_issued <= 0;
            n_done   <= 0;
            n_errors = 0;
        end else begin
            // Shadow the register file on every completed write
            if (psel && penable && pwrite && pready) begin
                case (paddr[5:3])
                    REG_ORDER_MODE:   mode_q   <= pwdata[1:0];
                    REG_DRIFT_PERIOD: period_q <= pwdata[K_W-1:0];
                    REG_SLIP_K0:      k0_q     <= pwdata[K_W-1:0];
                    REG_SLIP_K1:      k1_q     <= pwdata[K_W-1:0];
                    REG_SLIP_K2:      k2_q     <= pwdata[K_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                drift_q.push_back(predict_drift(i_item));
                n_issued <= n_issued + 1;
            end
            if (o_strobe) begin
                n_done <= n_done + 1;
                if (drift_q.size() == 0) begin
                    report_mismatch("result with no particle in flight");
                end else begin
                    want = drift_q.pop_front();
                    if (o_item.time_out !== want.time_out) begin
                        report_mismatch($sformatf("time_out %h, want %h",
                                                  o_item.time_out, want.time_out));
                    end
                    if (o_item.overflow_flag !== want.overflow_flag) begin
                        report_mismatch($sformatf("overflow_flag %b, want %b",
                                                  o_item.overflow_flag, want.overflow_flag));
                    end
                    if (o_item.last_out !== want.last_out) begin
                        report_mismatch($sformatf("last_out %b, want %b",
                                                  o_item.last_out, want.last_out));
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import ldk_pkg::*;
;

    // Index past the end of the register file; writes there must be dropped
    localparam logic [2:0] REG_UNMAPPED = 3'd5;
    localparam int         N_PHASES     = 12;
    localparam int         PHASE_ITEMS  = 134;
    localparam int         DRAIN_CYCLES = 100;   // comfortably past the pipeline depth

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_in_item          i_item  = '0;
    logic              o_strobe;
    t_out_item         o_item;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int n_errors;
    int n_pending;
    int idle_pct;

    longitudinal_drift_kick u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_item   (o_item),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ldk_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_strobe  (o_strobe),
        .o_item    (o_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .n_errors  (n_errors),
        .n_pending (n_pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the pipe hangs
    initial begin
        #2000000;
        $display("longitudinal_drift_kick test failed");
        $finish;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Pick a coefficient: an extreme, zero, a small value or a fully random one.
    function automatic logic [K_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0: return {1'b0, {(K_W - 1){1'b1}}};
            1: return {1'b1, {(K_W - 1){1'b0}}};
            2: return '0;
            3: return K_W'($signed(24'($urandom)));
            default: return K_W'(rand64());
        endcase
    endfunction

    function automatic t_in_item make_particle();
        t_in_item it;
        case ($urandom_range(0, 4))
            0: it.energy_offset = E_W'($signed(21'($urandom)));
            1: it.energy_offset = E_W'($signed(31'($urandom)));
            2: begin
                case ($urandom_range(0, 4))
                    0: it.energy_offset = {1'b0, {(E_W - 1){1'b1}}};
                    1: it.energy_offset = {1'b1, {(E_W - 1){1'b0}}};
                    2: it.energy_offset = '0;
                    3: it.energy_offset = E_W'(1);
                    default: it.energy_offset = '1;
                endcase
            end
            default: it.energy_offset = E_W'(rand64());
        endcase
        case ($urandom_range(0, 5))
            0: it.time_in = TMAX - T_W'($urandom_range(0, 1000));
            1: it.time_in = TMIN + T_W'($urandom_range(0, 1000));
            default: it.time_in = T_W'(rand64());
        endcase
        it.last_in = 1'($urandom_range(0, 1));
        return it;
    endfunction

    // Issue one particle, with a random gap first at a chance of idle_pct percent; hold until accepted.
    task automatic issue_particle(input t_in_item it);
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Drain the pipe, then reprogram every register and sometimes write an unmapped index.
    task automatic load_settings(input logic [1:0] mode, input logic [K_W-1:0] per,
                                 input logic [K_W-1:0] k0, input logic [K_W-1:0] k1,
                                 input logic [K_W-1:0] k2);
        start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        apb_write(REG_ORDER_MODE, {62'd0, mode});
        apb_write(REG_DRIFT_PERIOD, {16'd0, per});
        apb_write(REG_SLIP_K0, {{16{k0[K_W-1]}}, k0});
        apb_write(REG_SLIP_K1, {{16{k1[K_W-1]}}, k1});
        apb_write(REG_SLIP_K2, {{16{k2[K_W-1]}}, k2});
        if ($urandom_range(0, 2) == 0) begin
            apb_write(REG_UNMAPPED + 3'($urandom_range(0, 2)), rand64());
        end
    endtask

    // Corner particles: energy and time at their limits, zero and unit steps
    task automatic corner_particles();
        t_in_item it;
        logic [E_W-1:0] de_set [6];
        logic [T_W-1:0] t_set  [3];
        de_set = '{{1'b0, {(E_W - 1){1'b1}}}, {1'b1, {(E_W - 1){1'b0}}}, '0, E_W'(1), '1,
                   {1'b1, {(E_W - 2){1'b0}}, 1'b1}};
        t_set  = '{'0, TMAX, TMIN};
        for (int i = 0; i < 12; i++) begin
            it.energy_offset = de_set[i % 6];
            it.time_in       = t_set[i % 3];
            it.last_in       = i[0];
            issue_particle(it);
        end
    endtask

    initial begin
        logic [1:0] mode;
        idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings first: order 1, zero period
        corner_particles();

        // Largest period and coefficients: exact order 3 saturates hard
        load_settings(MODE_ORDER3, '1, {1'b0, {(K_W - 1){1'b1}}},
                      {1'b0, {(K_W - 1){1'b1}}}, {1'b0, {(K_W - 1){1'b1}}});
        corner_particles();

        // Simple drift with the most negative coefficients
        load_settings(MODE_SIMPLE, '1, {1'b1, {(K_W - 1){1'b0}}},
                      {1'b1, {(K_W - 1){1'b0}}}, {1'b1, {(K_W - 1){1'b0}}});
        corner_particles();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            mode = 2'(ph);
            load_settings(mode, ($urandom_range(0, 3) == 0) ? '1 : K_W'(rand64()),
                          pick_coeff(), pick_coeff(), pick_coeff());
            case (ph / 4)
                0: idle_pct = 31;
                1: idle_pct = 47;
                default: idle_pct = 0;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue_particle(make_particle());
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("longitudinal_drift_kick test passed");
        end else begin
            $display("longitudinal_drift_kick test failed");
        end
        $finish;
    end

endmodule
